// ----- hdl/ttsa_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tiled tensor slot address package
// Shared payload types, register indexes, status codes and the helper
// functions for division by the tile size through a reciprocal.
// ----------------------------------------------------------------------------
package ttsa_pkg;

    localparam int COORD_W     = 16;
    localparam int SLOT_W      = 64;
    localparam int NUM_LEAD    = 6;
    localparam int NUM_REGS    = 8;
    localparam int NUM_DIGITS  = NUM_LEAD + 4;
    localparam int REG_IDX_W   = 3;
    localparam int DIV_W       = COORD_W + 1;
    localparam int RECIP_W     = 33;
    localparam int RECIP_SHIFT = 32;

    // Configuration register indexes.
    localparam logic [REG_IDX_W-1:0] REG_DIM_0    = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_DIM_1    = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_DIM_2    = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_DIM_3    = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_DIM_4    = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_DIM_5    = 3'd5;
    localparam logic [REG_IDX_W-1:0] REG_DIM_ROWS = 3'd6;
    localparam logic [REG_IDX_W-1:0] REG_DIM_COLS = 3'd7;

    // Digit positions of the mixed-radix fold, outermost first.
    localparam int DIG_ROW_TILE = 6;
    localparam int DIG_COL_TILE = 7;
    localparam int DIG_ROW_IN   = 8;
    localparam int DIG_COL_IN   = 9;

    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_RANGE = 2'd1;
    localparam logic [1:0] STATUS_OVF   = 2'd2;

    typedef struct packed {
        logic [COORD_W-1:0] coord_0;
        logic [COORD_W-1:0] coord_1;
        logic [COORD_W-1:0] coord_2;
        logic [COORD_W-1:0] coord_3;
        logic [COORD_W-1:0] coord_4;
        logic [COORD_W-1:0] coord_5;
        logic [COORD_W-1:0] row_coord;
        logic [COORD_W-1:0] col_coord;
    } req_t;

    typedef struct packed {
        logic [SLOT_W-1:0] slot;
        logic [1:0]        status;
    } rsp_t;

    typedef logic [NUM_REGS-1:0][COORD_W-1:0]   dims_t;
    typedef logic [NUM_DIGITS-1:0][COORD_W-1:0] digits_t;

    // Register contents as seen by the datapath.
    typedef struct packed {
        dims_t              dims;
        logic [COORD_W-1:0] tiles_rows;
        logic [COORD_W-1:0] tiles_cols;
    } cfg_view_t;

    // Item after the range check and the split into tile and in-tile parts.
    typedef struct packed {
        logic    range_err;
        digits_t digits;
    } work_t;

    // Item inside the fold pipeline.
    typedef struct packed {
        logic              range_err;
        logic              ovf;
        logic [SLOT_W-1:0] acc;
        digits_t           digits;
    } fold_t;

    typedef struct packed {
        logic [DIV_W-1:0] q;
        logic [DIV_W-1:0] r;
    } qr_t;

    // Quotient estimate: at most one below the true quotient.
    function automatic logic [DIV_W-1:0] quot_est(input logic [DIV_W-1:0] v,
                                                   input logic [RECIP_W-1:0] recip);
        logic [DIV_W+RECIP_W-2:0] p;
        p = v * recip;
        return p[DIV_W+RECIP_W-2:RECIP_SHIFT];
    endfunction

    // One compare and subtract brings the estimate to the exact quotient.
    function automatic qr_t div_fix(input logic [DIV_W-1:0] v,
                                    input logic [DIV_W-1:0] q_est,
                                    input logic [DIV_W-1:0] t);
        logic [2*DIV_W-1:0] qt;
        logic [DIV_W-1:0]   r;
        qr_t                res;
        qt = q_est * t;
        r  = v - qt[DIV_W-1:0];
        if (r >= t)
        begin
            res.q = q_est + DIV_W'(1);
            res.r = r - t;
        end
        else
        begin
            res.q = q_est;
            res.r = r;
        end
        return res;
    endfunction

endpackage

// ----- hdl/tiled_tensor_slot_address.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tiled tensor slot address
// Maps one coordinate tuple to its element slot in a tiled tensor layout.
// ----------------------------------------------------------------------------
// Usage:
// A request on req (valid/ready) carries one coordinate tuple; the response
// on rsp (valid/ready) carries the slot and a status: ok, coordinate out of
// range (slot zero), or slot overflow past 64 bits (slot zero). A range
// error wins over overflow. Dimensions are written through cfg_we,
// cfg_index and cfg_wdata while no request is in flight.
// The slot is built as one mixed-radix number, outermost digit first:
// leading coordinates with the leading dimensions as radices, then the tile
// row and tile column with the tile counts per plane, then the row and
// column inside the tile with the tile size. Each digit is one fold stage
// with a 64x16 multiply and add.
// A request passes through two front stages for the range check and the
// split by the tile size, then through MAX_RANK + 2 fold stages. Throughput
// is one request per cycle while the receiver takes responses.
// When the receiver stalls, requests fill the bubbles of the pipeline and
// req_ready falls only once every stage holds a request. Reset empties the
// pipeline and sets every dimension to one.
// ----------------------------------------------------------------------------
module tiled_tensor_slot_address
    import ttsa_pkg::*;
#(
    parameter int TILE_SIZE = 32,
    parameter int MAX_RANK  = 8
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [REG_IDX_W-1:0] cfg_index,
    input  logic [COORD_W-1:0]   cfg_wdata,
    input  logic                 req_valid,
    output logic                 req_ready,
    input  req_t                 req,
    output logic                 rsp_valid,
    input  logic                 rsp_ready,
    output rsp_t                 rsp
);

    // Number of fold steps and the first digit that takes part; with a
    // smaller rank the outer leading dimensions are skipped entirely.
    localparam int NUM_STEPS = MAX_RANK + 2;
    localparam int DIG_FIRST = NUM_DIGITS - NUM_STEPS;

    cfg_view_t cfg;
    digits_t   radix;

    logic  front_valid, front_ready;
    work_t front_data;

    logic  [NUM_STEPS:0] fold_valid;
    logic  [NUM_STEPS:0] fold_ready;
    fold_t               fold_data [NUM_STEPS+1];

    ttsa_regs #(
        .TILE_SIZE (TILE_SIZE)
    ) u_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    // Radix of each digit. The user is to change the registers only while the
    // block is empty (not enforced here), so every stage reads them directly.
    always_comb
    begin
        for (int i = 0; i < NUM_LEAD; i++)
        begin
            radix[i] = cfg.dims[i];
        end
        radix[DIG_ROW_TILE] = cfg.tiles_rows;
        radix[DIG_COL_TILE] = cfg.tiles_cols;
        radix[DIG_ROW_IN]   = COORD_W'(TILE_SIZE);
        radix[DIG_COL_IN]   = COORD_W'(TILE_SIZE);
    end

    ttsa_front #(
        .TILE_SIZE (TILE_SIZE),
        .MAX_RANK  (MAX_RANK)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .dims      (cfg.dims),
        .in_valid  (req_valid),
        .in_ready  (req_ready),
        .in_data   (req),
        .out_valid (front_valid),
        .out_ready (front_ready),
        .out_data  (front_data)
    );

    // The fold starts from zero with a clear overflow flag.
    assign fold_valid[0]          = front_valid;
    assign front_ready            = fold_ready[0];
    assign fold_data[0].range_err = front_data.range_err;
    assign fold_data[0].ovf       = 1'b0;
    assign fold_data[0].acc       = '0;
    assign fold_data[0].digits    = front_data.digits;

    for (genvar k = 0; k < NUM_STEPS; k++)
    begin : g_fold
        ttsa_fold_stage u_stage (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (fold_valid[k]),
            .in_ready  (fold_ready[k]),
            .in_data   (fold_data[k]),
            .digit     (fold_data[k].digits[DIG_FIRST+k]),
            .radix     (radix[DIG_FIRST+k]),
            .out_valid (fold_valid[k+1]),
            .out_ready (fold_ready[k+1]),
            .out_data  (fold_data[k+1])
        );
    end

    // The last fold register is the output register.
    assign rsp_valid            = fold_valid[NUM_STEPS];
    assign fold_ready[NUM_STEPS] = rsp_ready;

    always_comb
    begin
        if (fold_data[NUM_STEPS].range_err)
        begin
            rsp.slot   = '0;
            rsp.status = STATUS_RANGE;
        end
        else if (fold_data[NUM_STEPS].ovf)
        begin
            rsp.slot   = '0;
            rsp.status = STATUS_OVF;
        end
        else
        begin
            rsp.slot   = fold_data[NUM_STEPS].acc;
            rsp.status = STATUS_OK;
        end
    end

endmodule

// ----- hdl/ttsa_regs.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Configuration registers
// Holds the dimension registers and derives the tile counts per plane
// over two register stages.
// ----------------------------------------------------------------------------
module ttsa_regs
    import ttsa_pkg::*;
#(
    parameter int TILE_SIZE = 32
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [REG_IDX_W-1:0] cfg_index,
    input  logic [COORD_W-1:0]   cfg_wdata,
    output cfg_view_t            cfg
);

    localparam logic [RECIP_W-1:0] TILE_RECIP = RECIP_W'((64'd1 << RECIP_SHIFT) / TILE_SIZE);
    localparam logic [DIV_W-1:0]   TILE_D     = DIV_W'(TILE_SIZE);

    dims_t            dims_reg;
    logic [DIV_W-1:0] rows_v_reg, cols_v_reg, rows_q_reg, cols_q_reg;
    logic [DIV_W-1:0] rows_v_next, cols_v_next;
    logic [COORD_W-1:0] tiles_rows_reg, tiles_cols_reg;
    qr_t              rows_qr, cols_qr;

    // Round up to whole tiles: (dim + T - 1) / T.
    assign rows_v_next = DIV_W'(dims_reg[REG_DIM_ROWS]) + DIV_W'(TILE_SIZE - 1);
    assign cols_v_next = DIV_W'(dims_reg[REG_DIM_COLS]) + DIV_W'(TILE_SIZE - 1);
    assign rows_qr     = div_fix(rows_v_reg, rows_q_reg, TILE_D);
    assign cols_qr     = div_fix(cols_v_reg, cols_q_reg, TILE_D);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_REGS; i++)
            begin
                dims_reg[i] <= COORD_W'(1);
            end
            rows_v_reg     <= TILE_D;
            cols_v_reg     <= TILE_D;
            rows_q_reg     <= DIV_W'(1);
            cols_q_reg     <= DIV_W'(1);
            tiles_rows_reg <= COORD_W'(1);
            tiles_cols_reg <= COORD_W'(1);
        end
        else
        begin
            if (cfg_we)
            begin
                dims_reg[cfg_index] <= cfg_wdata;
            end
            rows_v_reg     <= rows_v_next;
            cols_v_reg     <= cols_v_next;
            rows_q_reg     <= quot_est(rows_v_next, TILE_RECIP);
            cols_q_reg     <= quot_est(cols_v_next, TILE_RECIP);
            tiles_rows_reg <= rows_qr.q[COORD_W-1:0];
            tiles_cols_reg <= cols_qr.q[COORD_W-1:0];
        end
    end

    assign cfg.dims       = dims_reg;
    assign cfg.tiles_rows = tiles_rows_reg;
    assign cfg.tiles_cols = tiles_cols_reg;

endmodule

// ----- hdl/ttsa_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Front end
// Two stages: range check with quotient estimates, then the correction that
// splits the row and column coordinates into tile and in-tile digits.
// ----------------------------------------------------------------------------
module ttsa_front
    import ttsa_pkg::*;
#(
    parameter int TILE_SIZE = 32,
    parameter int MAX_RANK  = 8
)
(
    input  logic  clk,
    input  logic  rst_n,
    input  dims_t dims,
    input  logic  in_valid,
    output logic  in_ready,
    input  req_t  in_data,
    output logic  out_valid,
    input  logic  out_ready,
    output work_t out_data
);

    localparam int FIRST = NUM_LEAD - (MAX_RANK - 2);
    localparam logic [RECIP_W-1:0] TILE_RECIP = RECIP_W'((64'd1 << RECIP_SHIFT) / TILE_SIZE);
    localparam logic [DIV_W-1:0]   TILE_D     = DIV_W'(TILE_SIZE);

    typedef struct packed {
        logic                             range_err;
        logic [NUM_REGS-1:0][COORD_W-1:0] coords;
        logic [DIV_W-1:0]                 row_q;
        logic [DIV_W-1:0]                 col_q;
    } stage_a_t;

    logic     a_valid_reg, b_valid_reg;
    stage_a_t a_data_reg, a_next;
    work_t    b_data_reg, b_next;
    logic     b_ready;
    qr_t      row_qr, col_qr;

    always_comb
    begin
        a_next.coords[0] = in_data.coord_0;
        a_next.coords[1] = in_data.coord_1;
        a_next.coords[2] = in_data.coord_2;
        a_next.coords[3] = in_data.coord_3;
        a_next.coords[4] = in_data.coord_4;
        a_next.coords[5] = in_data.coord_5;
        a_next.coords[REG_DIM_ROWS] = in_data.row_coord;
        a_next.coords[REG_DIM_COLS] = in_data.col_coord;
        a_next.range_err = 1'b0;
        for (int i = FIRST; i < NUM_REGS; i++)
        begin
            if (a_next.coords[i] >= dims[i])
            begin
                a_next.range_err = 1'b1;
            end
        end
        a_next.row_q = quot_est(DIV_W'(in_data.row_coord), TILE_RECIP);
        a_next.col_q = quot_est(DIV_W'(in_data.col_coord), TILE_RECIP);
    end

    assign row_qr = div_fix(DIV_W'(a_data_reg.coords[REG_DIM_ROWS]), a_data_reg.row_q, TILE_D);
    assign col_qr = div_fix(DIV_W'(a_data_reg.coords[REG_DIM_COLS]), a_data_reg.col_q, TILE_D);

    always_comb
    begin
        b_next.range_err = a_data_reg.range_err;
        for (int i = 0; i < NUM_LEAD; i++)
        begin
            b_next.digits[i] = a_data_reg.coords[i];
        end
        b_next.digits[DIG_ROW_TILE] = row_qr.q[COORD_W-1:0];
        b_next.digits[DIG_COL_TILE] = col_qr.q[COORD_W-1:0];
        b_next.digits[DIG_ROW_IN]   = row_qr.r[COORD_W-1:0];
        b_next.digits[DIG_COL_IN]   = col_qr.r[COORD_W-1:0];
    end

    assign b_ready   = !b_valid_reg || out_ready;
    assign in_ready  = !a_valid_reg || b_ready;
    assign out_valid = b_valid_reg;
    assign out_data  = b_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
            begin
                a_valid_reg <= in_valid;
            end
            if (b_ready)
            begin
                b_valid_reg <= a_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            a_data_reg <= a_next;
        end
        if (b_ready && a_valid_reg)
        begin
            b_data_reg <= b_next;
        end
    end

endmodule

// ----- hdl/ttsa_fold_stage.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Fold stage
// One mixed-radix step: acc * radix + digit, with a sticky flag that is set
// once the running value no longer fits in the slot width.
// ----------------------------------------------------------------------------
module ttsa_fold_stage
    import ttsa_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  fold_t              in_data,
    input  logic [COORD_W-1:0] digit,
    input  logic [COORD_W-1:0] radix,
    output logic               out_valid,
    input  logic               out_ready,
    output fold_t              out_data
);

    logic [SLOT_W+COORD_W-1:0] prod;
    logic [SLOT_W+COORD_W:0]   sum;
    fold_t                     data_next;
    fold_t                     data_reg;
    logic                      valid_reg;

    always_comb
    begin
        prod = in_data.acc * radix;
        sum  = {1'b0, prod} + (SLOT_W + COORD_W + 1)'(digit);
        data_next           = in_data;
        data_next.acc       = sum[SLOT_W-1:0];
        data_next.ovf       = in_data.ovf || (|sum[SLOT_W+COORD_W:SLOT_W]);
    end

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            data_reg <= data_next;
        end
    end

endmodule
